>>> rtl/core/hsigrb_pkg.sv
// Package: constants, sector codes and hue helpers for the HSI to GRB converter.
`timescale 1ns / 1ps

package hsigrb_pkg;

   localparam logic [8:0]  HueFull  = 9'd360;
   localparam logic [6:0]  PctMax   = 7'd100;
   localparam logic [13:0] PctSq    = 14'd10000;

   // floor(5*rem/3) for rem < 60 as (rem * FracMul) >> 9
   localparam logic [15:0] FracMul   = 16'd855;
   // floor(x/100) for x < 2^14 as (x * PctRecip) >> 21
   localparam logic [28:0] PctRecip  = 29'd20972;
   // floor(x/10000) for x <= 10^6 as (x * PctSqRecip) >> 34
   localparam logic [40:0] PctSqRecip = 41'd1717987;
   // floor(x/100) for x <= 25500 as (x * ByteRecip) >> 22
   localparam logic [30:0] ByteRecip = 31'd41944;

   typedef enum logic [2:0] {
      SECTOR_RED     = 3'd0,
      SECTOR_YELLOW  = 3'd1,
      SECTOR_GREEN   = 3'd2,
      SECTOR_CYAN    = 3'd3,
      SECTOR_BLUE    = 3'd4,
      SECTOR_MAGENTA = 3'd5
   } sector_type;

   function automatic sector_type hue_sector(logic [8:0] hue);
      sector_type sec;
      priority if (hue >= 9'd300) sec = SECTOR_MAGENTA;
      else if (hue >= 9'd240)     sec = SECTOR_BLUE;
      else if (hue >= 9'd180)     sec = SECTOR_CYAN;
      else if (hue >= 9'd120)     sec = SECTOR_GREEN;
      else if (hue >= 9'd60)      sec = SECTOR_YELLOW;
      else                        sec = SECTOR_RED;
      return sec;
   endfunction

   function automatic logic [8:0] sector_base(sector_type sec);
      logic [8:0] base;
      unique case (sec)
         SECTOR_RED:     base = 9'd0;
         SECTOR_YELLOW:  base = 9'd60;
         SECTOR_GREEN:   base = 9'd120;
         SECTOR_CYAN:    base = 9'd180;
         SECTOR_BLUE:    base = 9'd240;
         SECTOR_MAGENTA: base = 9'd300;
         default:        base = 9'd0;
      endcase
      return base;
   endfunction

endpackage

>>> rtl/core/hsi_to_grb_color_converter.sv
// Throughput one request per cycle, except while rsp_stall holds a waiting result.
// Seven register stages: sector split, fraction and P product, Q/T numerators,
// Q/T products, divide by 10000, channel select and *255, divide by 100.
// The whole pipeline holds while a result waits under rsp_stall.
// Reset (synchronous, active high) clears the stage valid bits only.
`timescale 1ns / 1ps

module hsi_to_grb_color_converter (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [8:0]  req_hue,
   input  logic [6:0]  req_saturation,
   input  logic [6:0]  req_intensity,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_in_range,
   output logic [7:0]  rsp_red,
   output logic [7:0]  rsp_green,
   output logic [7:0]  rsp_blue,
   output logic [23:0] rsp_grb_word
);
   import hsigrb_pkg::*;

   logic advance;

   // stage valid bits, index 1..6 internal, rsp is stage 7
   logic [6:1] vld_ff, vld_in;
   logic       rsp_valid_ff, rsp_valid_in;

   // stage 1
   logic [8:0] hue_wrap;
   logic [8:0] rem_full;
   logic       s1_ok_ff, s1_ok_in;
   sector_type s1_sec_ff, s1_sec_in;
   logic [5:0] s1_rem_ff, s1_rem_in;
   logic [6:0] s1_sat_ff, s1_sat_in;
   logic [6:0] s1_int_ff, s1_int_in;

   // stage 2
   logic [15:0] frac_prod;
   logic        s2_ok_ff, s2_ok_in;
   sector_type  s2_sec_ff, s2_sec_in;
   logic [6:0]  s2_frac_ff, s2_frac_in;
   logic [13:0] s2_pnum_ff, s2_pnum_in;
   logic [6:0]  s2_sat_ff, s2_sat_in;
   logic [6:0]  s2_int_ff, s2_int_in;

   // stage 3
   logic [13:0] fs_prod, sf_prod;
   logic [28:0] p_prod;
   logic        s3_ok_ff, s3_ok_in;
   sector_type  s3_sec_ff, s3_sec_in;
   logic [13:0] s3_qn_ff, s3_qn_in;
   logic [13:0] s3_tn_ff, s3_tn_in;
   logic [6:0]  s3_p_ff, s3_p_in;
   logic [6:0]  s3_int_ff, s3_int_in;

   // stage 4
   logic [20:0] qprod_full, tprod_full;
   logic        s4_ok_ff, s4_ok_in;
   sector_type  s4_sec_ff, s4_sec_in;
   logic [19:0] s4_qprod_ff, s4_qprod_in;
   logic [19:0] s4_tprod_ff, s4_tprod_in;
   logic [6:0]  s4_p_ff, s4_p_in;
   logic [6:0]  s4_int_ff, s4_int_in;

   // stage 5
   logic [40:0] q_div, t_div;
   logic        s5_ok_ff, s5_ok_in;
   sector_type  s5_sec_ff, s5_sec_in;
   logic [6:0]  s5_q_ff, s5_q_in;
   logic [6:0]  s5_t_ff, s5_t_in;
   logic [6:0]  s5_p_ff, s5_p_in;
   logic [6:0]  s5_int_ff, s5_int_in;

   // stage 6
   logic [6:0]  red_pct, green_pct, blue_pct;
   logic        s6_ok_ff, s6_ok_in;
   logic [14:0] s6_red_ff, s6_red_in;
   logic [14:0] s6_green_ff, s6_green_in;
   logic [14:0] s6_blue_ff, s6_blue_in;

   // stage 7 / output
   logic [30:0] red_div, green_div, blue_div;
   logic        rsp_ok_ff, rsp_ok_in;
   logic [7:0]  rsp_red_ff, rsp_red_in;
   logic [7:0]  rsp_green_ff, rsp_green_in;
   logic [7:0]  rsp_blue_ff, rsp_blue_in;

   assign advance   = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !advance;

   always_comb begin
      vld_in       = {vld_ff[5:1], req_valid};
      rsp_valid_in = vld_ff[6];
   end

   // stage 1: range check, hue 360 folds to 0, sector and remainder in degrees
   always_comb begin
      hue_wrap  = (req_hue == HueFull) ? 9'd0 : req_hue;
      s1_ok_in  = (req_hue <= HueFull) && (req_saturation <= PctMax)
                  && (req_intensity <= PctMax);
      s1_sec_in = hue_sector(hue_wrap);
      rem_full  = hue_wrap - sector_base(s1_sec_in);
      s1_rem_in = rem_full[5:0];
      s1_sat_in = req_saturation;
      s1_int_in = req_intensity;
   end

   // stage 2: fraction 0..98 and P numerator
   always_comb begin
      frac_prod  = 16'(s1_rem_ff) * FracMul;
      s2_frac_in = frac_prod[15:9];
      s2_pnum_in = 14'(s1_int_ff) * 14'(PctMax - s1_sat_ff);
      s2_ok_in   = s1_ok_ff;
      s2_sec_in  = s1_sec_ff;
      s2_sat_in  = s1_sat_ff;
      s2_int_in  = s1_int_ff;
   end

   // stage 3: Q and T numerators, P = pnum / 100
   always_comb begin
      fs_prod   = 14'(s2_frac_ff) * 14'(s2_sat_ff);
      sf_prod   = 14'(s2_sat_ff) * 14'(PctMax - s2_frac_ff);
      s3_qn_in  = PctSq - fs_prod;
      s3_tn_in  = PctSq - sf_prod;
      p_prod    = 29'(s2_pnum_ff) * PctRecip;
      s3_p_in   = p_prod[27:21];
      s3_ok_in  = s2_ok_ff;
      s3_sec_in = s2_sec_ff;
      s3_int_in = s2_int_ff;
   end

   // stage 4: scale numerators by intensity
   always_comb begin
      qprod_full  = 21'(s3_int_ff) * 21'(s3_qn_ff);
      tprod_full  = 21'(s3_int_ff) * 21'(s3_tn_ff);
      s4_qprod_in = qprod_full[19:0];
      s4_tprod_in = tprod_full[19:0];
      s4_ok_in    = s3_ok_ff;
      s4_sec_in   = s3_sec_ff;
      s4_p_in     = s3_p_ff;
      s4_int_in   = s3_int_ff;
   end

   // stage 5: divide by 10000
   always_comb begin
      q_div     = 41'(s4_qprod_ff) * PctSqRecip;
      t_div     = 41'(s4_tprod_ff) * PctSqRecip;
      s5_q_in   = q_div[40:34];
      s5_t_in   = t_div[40:34];
      s5_ok_in  = s4_ok_ff;
      s5_sec_in = s4_sec_ff;
      s5_p_in   = s4_p_ff;
      s5_int_in = s4_int_ff;
   end

   // stage 6: pick channels per sector, times 255
   always_comb begin
      unique case (s5_sec_ff)
         SECTOR_RED: begin
            red_pct = s5_int_ff; green_pct = s5_t_ff;   blue_pct = s5_p_ff;
         end
         SECTOR_YELLOW: begin
            red_pct = s5_q_ff;   green_pct = s5_int_ff; blue_pct = s5_p_ff;
         end
         SECTOR_GREEN: begin
            red_pct = s5_p_ff;   green_pct = s5_int_ff; blue_pct = s5_t_ff;
         end
         SECTOR_CYAN: begin
            red_pct = s5_p_ff;   green_pct = s5_q_ff;   blue_pct = s5_int_ff;
         end
         SECTOR_BLUE: begin
            red_pct = s5_t_ff;   green_pct = s5_p_ff;   blue_pct = s5_int_ff;
         end
         default: begin
            red_pct = s5_int_ff; green_pct = s5_p_ff;   blue_pct = s5_q_ff;
         end
      endcase
      s6_red_in   = {red_pct, 8'd0} - 15'(red_pct);
      s6_green_in = {green_pct, 8'd0} - 15'(green_pct);
      s6_blue_in  = {blue_pct, 8'd0} - 15'(blue_pct);
      s6_ok_in    = s5_ok_ff;
   end

   // stage 7: divide by 100, zero colors when out of range
   always_comb begin
      red_div      = 31'(s6_red_ff) * ByteRecip;
      green_div    = 31'(s6_green_ff) * ByteRecip;
      blue_div     = 31'(s6_blue_ff) * ByteRecip;
      rsp_ok_in    = s6_ok_ff;
      rsp_red_in   = s6_ok_ff ? red_div[29:22] : 8'd0;
      rsp_green_in = s6_ok_ff ? green_div[29:22] : 8'd0;
      rsp_blue_in  = s6_ok_ff ? blue_div[29:22] : 8'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         vld_ff       <= vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_ok_ff     <= s1_ok_in;
         s1_sec_ff    <= s1_sec_in;
         s1_rem_ff    <= s1_rem_in;
         s1_sat_ff    <= s1_sat_in;
         s1_int_ff    <= s1_int_in;

         s2_ok_ff     <= s2_ok_in;
         s2_sec_ff    <= s2_sec_in;
         s2_frac_ff   <= s2_frac_in;
         s2_pnum_ff   <= s2_pnum_in;
         s2_sat_ff    <= s2_sat_in;
         s2_int_ff    <= s2_int_in;

         s3_ok_ff     <= s3_ok_in;
         s3_sec_ff    <= s3_sec_in;
         s3_qn_ff     <= s3_qn_in;
         s3_tn_ff     <= s3_tn_in;
         s3_p_ff      <= s3_p_in;
         s3_int_ff    <= s3_int_in;

         s4_ok_ff     <= s4_ok_in;
         s4_sec_ff    <= s4_sec_in;
         s4_qprod_ff  <= s4_qprod_in;
         s4_tprod_ff  <= s4_tprod_in;
         s4_p_ff      <= s4_p_in;
         s4_int_ff    <= s4_int_in;

         s5_ok_ff     <= s5_ok_in;
         s5_sec_ff    <= s5_sec_in;
         s5_q_ff      <= s5_q_in;
         s5_t_ff      <= s5_t_in;
         s5_p_ff      <= s5_p_in;
         s5_int_ff    <= s5_int_in;

         s6_ok_ff     <= s6_ok_in;
         s6_red_ff    <= s6_red_in;
         s6_green_ff  <= s6_green_in;
         s6_blue_ff   <= s6_blue_in;

         rsp_ok_ff    <= rsp_ok_in;
         rsp_red_ff   <= rsp_red_in;
         rsp_green_ff <= rsp_green_in;
         rsp_blue_ff  <= rsp_blue_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_in_range = rsp_ok_ff;
   assign rsp_red      = rsp_red_ff;
   assign rsp_green    = rsp_green_ff;
   assign rsp_blue     = rsp_blue_ff;
   assign rsp_grb_word = {rsp_green_ff, rsp_red_ff, rsp_blue_ff};

endmodule

>>> verif/hsi_to_grb_color_converter_tb.sv
// Testbench: random and directed HSI requests checked against a GRB color predictor.
`timescale 1ns / 1ps

module hsi_to_grb_color_converter_tb;
   import hsigrb_pkg::*;

   localparam int unsigned SectorDeg  = 60;
   localparam int unsigned ByteFull   = 255;
   localparam int          RandomReqs = 1300;
   localparam int          IdleLimit  = 4000;
   localparam int          TailCycles = 24;

   typedef struct {
      logic [8:0] hue;
      logic [6:0] saturation;
      logic [6:0] intensity;
      bit         hold_off;   // wait for all results before presenting
   } hsi_request_type;

   typedef struct {
      logic        in_range;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [23:0] grb_word;
   } grb_color_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [8:0]  req_hue = '0;
   logic [6:0]  req_saturation = '0;
   logic [6:0]  req_intensity = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_in_range;
   logic [7:0]  rsp_red;
   logic [7:0]  rsp_green;
   logic [7:0]  rsp_blue;
   logic [23:0] rsp_grb_word;

   hsi_request_type pending_requests[$];
   grb_color_type   expected_colors[$];
   int              fail_count = 0;
   int              idle_cycles = 0;
   int              sent_count = 0;
   int              gap_left = 0;
   int              stall_left = 0;
   int              cycle_count = 0;

   hsi_to_grb_color_converter u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_hue        (req_hue),
      .req_saturation (req_saturation),
      .req_intensity  (req_intensity),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_in_range   (rsp_in_range),
      .rsp_red        (rsp_red),
      .rsp_green      (rsp_green),
      .rsp_blue       (rsp_blue),
      .rsp_grb_word   (rsp_grb_word)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic grb_color_type predict_grb(logic [8:0] hue, logic [6:0] sat,
                                                 logic [6:0] inten);
      grb_color_type res;
      int unsigned   h, s, i, frac, p, q, t, r, g, b;
      sector_type    sec;
      res = '{default: '0};
      h = hue;
      s = sat;
      i = inten;
      if (h > HueFull || s > PctMax || i > PctMax) return res;
      if (h == HueFull) h = 0;
      sec  = sector_type'(h / SectorDeg);
      frac = PctMax * h / SectorDeg - PctMax * (h / SectorDeg);
      p = i * (PctMax - s) / PctMax;
      q = i * (PctSq - frac * s) / PctSq;
      t = i * (PctSq - s * (PctMax - frac)) / PctSq;
      case (sec)
         SECTOR_RED:    begin r = i; g = t; b = p; end
         SECTOR_YELLOW: begin r = q; g = i; b = p; end
         SECTOR_GREEN:  begin r = p; g = i; b = t; end
         SECTOR_CYAN:   begin r = p; g = q; b = i; end
         SECTOR_BLUE:   begin r = t; g = p; b = i; end
         default:       begin r = i; g = p; b = q; end
      endcase
      res.in_range = 1'b1;
      res.red      = 8'(r * ByteFull / PctMax);
      res.green    = 8'(g * ByteFull / PctMax);
      res.blue     = 8'(b * ByteFull / PctMax);
      res.grb_word = {res.green, res.red, res.blue};
      return res;
   endfunction

   // mostly short idles, a few long ones
   function automatic int pick_idle();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 45) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic hsi_request_type make_request(int hue, int sat, int inten);
      hsi_request_type req;
      req.hue        = 9'(hue);
      req.saturation = 7'(sat);
      req.intensity  = 7'(inten);
      req.hold_off   = 1'b0;
      return req;
   endfunction

   function automatic hsi_request_type random_request();
      hsi_request_type req;
      int              roll;
      roll = $urandom_range(0, 99);
      if (roll < 78) begin
         req = make_request($urandom_range(0, 360), $urandom_range(0, 100),
                            $urandom_range(0, 100));
      end else if (roll < 85) begin
         // sector edges and full circle
         req = make_request(60 * $urandom_range(0, 6) - $urandom_range(0, 1) + 1,
                            $urandom_range(0, 100), $urandom_range(0, 100));
         if (req.hue > HueFull) req.hue = HueFull;
      end else begin
         req = make_request($urandom_range(0, 511), $urandom_range(0, 127),
                            $urandom_range(0, 127));
      end
      req.hold_off = ($urandom_range(0, 149) == 0);
      return req;
   endfunction

   // request driver
   always @(posedge clock) begin
      hsi_request_type next_req;
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_colors.push_back(predict_grb(req_hue, req_saturation, req_intensity));
            sent_count++;
         end
         if (!req_valid || !req_stall) begin
            if (gap_left != 0) begin
               req_valid <= 1'b0;
               gap_left--;
            end else if (pending_requests.size() != 0 &&
                         !(pending_requests[0].hold_off && expected_colors.size() != 0)) begin
               next_req = pending_requests.pop_front();
               req_valid      <= 1'b1;
               req_hue        <= next_req.hue;
               req_saturation <= next_req.saturation;
               req_intensity  <= next_req.intensity;
               // alternate between back-to-back stretches and gappy stretches
               gap_left = ((sent_count / 150) % 2 == 0) ? 0 : pick_idle();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result monitor and stall generator
   always @(posedge clock) begin
      grb_color_type exp_color;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
         cycle_count = 0;
      end else begin
         cycle_count++;
         if (rsp_valid && !rsp_stall) begin
            if (expected_colors.size() == 0) begin
               $error("unexpected result: grb_word %06h", rsp_grb_word);
               fail_count++;
            end else begin
               exp_color = expected_colors.pop_front();
               if (rsp_in_range !== exp_color.in_range) begin
                  $error("in_range: expected %0d, actual %0d", exp_color.in_range,
                         rsp_in_range);
                  fail_count++;
               end
               if (rsp_red !== exp_color.red) begin
                  $error("red: expected %0d, actual %0d", exp_color.red, rsp_red);
                  fail_count++;
               end
               if (rsp_green !== exp_color.green) begin
                  $error("green: expected %0d, actual %0d", exp_color.green, rsp_green);
                  fail_count++;
               end
               if (rsp_blue !== exp_color.blue) begin
                  $error("blue: expected %0d, actual %0d", exp_color.blue, rsp_blue);
                  fail_count++;
               end
               if (rsp_grb_word !== exp_color.grb_word) begin
                  $error("grb_word: expected %06h, actual %06h", exp_color.grb_word,
                         rsp_grb_word);
                  fail_count++;
               end
            end
         end
         if (stall_left != 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else if ((cycle_count / 700) % 2 == 1 && $urandom_range(0, 3) == 0) begin
            rsp_stall <= 1'b1;
            stall_left = pick_idle();
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // watchdog: no progress on either channel for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
         $display("*** FAILED ***");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      hsi_request_type req;
      // extremes, every sector, full circle and out-of-range inputs
      pending_requests.push_back(make_request(0, 0, 0));
      pending_requests.push_back(make_request(0, 100, 100));
      pending_requests.push_back(make_request(360, 100, 100));
      pending_requests.push_back(make_request(360, 57, 73));
      pending_requests.push_back(make_request(59, 100, 100));
      pending_requests.push_back(make_request(60, 100, 100));
      pending_requests.push_back(make_request(119, 80, 90));
      pending_requests.push_back(make_request(150, 100, 100));
      pending_requests.push_back(make_request(180, 45, 100));
      pending_requests.push_back(make_request(210, 100, 60));
      pending_requests.push_back(make_request(270, 100, 100));
      pending_requests.push_back(make_request(330, 100, 100));
      pending_requests.push_back(make_request(359, 100, 100));
      pending_requests.push_back(make_request(45, 1, 99));
      pending_requests.push_back(make_request(200, 100, 0));
      pending_requests.push_back(make_request(100, 0, 100));
      pending_requests.push_back(make_request(361, 50, 50));
      pending_requests.push_back(make_request(511, 127, 127));
      pending_requests.push_back(make_request(0, 101, 50));
      pending_requests.push_back(make_request(0, 50, 101));
      pending_requests.push_back(make_request(120, 127, 0));
      pending_requests.push_back(make_request(256, 64, 64));
      for (int n = 0; n < RandomReqs; n++) begin
         req = random_request();
         if (n == 0) req.hold_off = 1'b1;
         pending_requests.push_back(req);
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      while (pending_requests.size() != 0 || req_valid) @(posedge clock);
      while (expected_colors.size() != 0) @(posedge clock);
      repeat (TailCycles) @(posedge clock);

      if (fail_count == 0 && expected_colors.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
